// ===== sv/mpw_pkg.sv =====
// Types and constants shared by the membership probability weight block.
// No dependencies.
`default_nettype none
package mpw_pkg;
  typedef enum logic [1:0] {
    CFG_LAMBDA_NORM = 2'd0,
    CFG_CUT_RADIUS  = 2'd1,
    CFG_SOFT_WIDTH  = 2'd2,
    CFG_ERF_SCALE   = 2'd3
  } cfg_idx_t;
endpackage
`default_nettype wire

// ===== sv/membership_probability_weight.sv =====
// Top level of the membership probability weight block.
// Depends on mpw_pkg.
//
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid/in_ready   | densities, radius, weight, last flag
// out_    | output    | out_valid/out_ready | probability, radial factor, weight, last flag
// cfg_    | input     | cfg_we              | register index and data
//
// One item is accepted per cycle while the output is not stalled. There are
// DIV_STAGES + 6 register stages; the depth is set by the restoring divider for p,
// which retires one quotient bit per stage.
// The erf table is built at elaboration, so no pass runs after reset.
// A stall freezes every stage at once; in_ready is out_ready or an empty final stage.
`default_nettype none
module membership_probability_weight #(
  parameter int ERF_TABLE_DEPTH = 256,
  parameter int FRAC_BITS = 15
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_model_density,
  input  wire logic [31:0] in_background_density,
  input  wire logic [15:0] in_radius,
  input  wire logic [15:0] in_prior_weight,
  input  wire logic        in_last_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_membership_prob,
  output logic [15:0]      out_radial_factor,
  output logic [15:0]      out_member_weight,
  output logic             out_last_out,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  import mpw_pkg::*;

  localparam int TW = FRAC_BITS + 2;
  localparam int DEPTH_LOG2 = $clog2(ERF_TABLE_DEPTH);
  localparam int IW = DEPTH_LOG2 + 1;
  localparam int DIV_STAGES = FRAC_BITS + 1;
  localparam int NST = DIV_STAGES + 6;
  localparam int SP = DIV_STAGES + 1;
  localparam logic [63:0] ONE_G = 64'd1 << 28;
  localparam logic [63:0] ERF_STEP_SQ =
    (64'd1 << 32) / (64'(ERF_TABLE_DEPTH) * 64'(ERF_TABLE_DEPTH));

  typedef logic [TW-1:0] tab_t [ERF_TABLE_DEPTH+1];

  // Restoring fraction division at elaboration
  function automatic logic [63:0] fdiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = 64'd0;
    r = num;
    if (r >= den) begin
      q = 64'd1;
      r = r - den;
    end
    for (int i = 0; i < FRAC_BITS; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  // Build the normalised erf table by Gaussian trapezoid sums
  function automatic tab_t build_tab();
    tab_t tb;
    logic [63:0] raw [ERF_TABLE_DEPTH+1];
    logic [63:0] t, e, q, q2, g, r, s, gn;
    t = ONE_G;
    e = ONE_G;
    s = 64'd0;
    for (int k = 1; k <= 8; k++) begin
      t = ((t * ERF_STEP_SQ) >> 28) / 64'(k);
      if ((k % 2) == 1) e = e - t;
      else e = e + t;
    end
    q = e;
    q2 = (q * q) >> 28;
    g = ONE_G;
    r = q;
    raw[0] = 64'd0;
    for (int k = 0; k < ERF_TABLE_DEPTH; k++) begin
      gn = (g * r) >> 28;
      s = s + g + gn;
      raw[k+1] = s;
      g = gn;
      r = (r * q2) >> 28;
    end
    for (int k = 0; k <= ERF_TABLE_DEPTH; k++) tb[k] = TW'(fdiv(raw[k], s));
    return tb;
  endfunction

  localparam tab_t ERF_TAB = build_tab();
  localparam logic [TW-1:0] ONE = TW'(1) << FRAC_BITS;

  // Configuration registers
  logic [31:0] lambda_norm_r;
  logic [15:0] cut_radius_r, soft_width_r, erf_scale_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lambda_norm_r <= 32'd65536;
      cut_radius_r  <= 16'd4096;
      soft_width_r  <= 16'd0;
      erf_scale_r   <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LAMBDA_NORM: lambda_norm_r <= cfg_wdata;
        CFG_CUT_RADIUS:  cut_radius_r  <= cfg_wdata[15:0];
        CFG_SOFT_WIDTH:  soft_width_r  <= cfg_wdata[15:0];
        CFG_ERF_SCALE:   erf_scale_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Pipeline bookkeeping: one global enable
  logic [NST-1:0] vld_r;
  logic adv;
  assign adv = out_ready || !vld_r[NST-1];
  assign in_ready = adv;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NST-2:0], in_valid};
  end

  // Per-stage payload, indexed by stage
  logic [15:0]   w_r    [SP+2];
  logic          last_r [NST];
  logic [TW-1:0] th_r   [3:NST-1];

  // Divider operands, indexed by stage
  logic [48:0]        rem_r [1:DIV_STAGES];
  logic [48:0]        den_r [1:DIV_STAGES];
  logic [FRAC_BITS:0] q_r   [2:DIV_STAGES+1];
  logic               zd_r  [1:DIV_STAGES+1];

  // Stage 0: capture, product A (one 32x32 multiply), theta geometry
  logic [47:0] a0_r;
  logic [31:0] bg0_r;
  logic        hard0_r, in_hard0_r, below0_r, above0_r, dpos0_r;
  logic [16:0] ad0_r;
  logic [15:0] es0_r;
  always_ff @(posedge clk) begin
    logic [63:0] prod;
    logic signed [19:0] lo, hi, rs, d;
    if (adv) begin
      prod = 64'(lambda_norm_r) * 64'(in_model_density);
      lo = 20'(signed'({1'b0, cut_radius_r})) - 20'd5 * 20'(signed'({1'b0, soft_width_r}));
      hi = 20'(signed'({1'b0, cut_radius_r})) + 20'd5 * 20'(signed'({1'b0, soft_width_r}));
      rs = 20'(signed'({1'b0, in_radius}));
      d  = 20'(signed'({1'b0, cut_radius_r})) - rs;
      a0_r       <= prod[63:16];
      bg0_r      <= in_background_density;
      hard0_r    <= (soft_width_r == 16'd0);
      in_hard0_r <= (in_radius < cut_radius_r);
      below0_r   <= (rs < lo);
      above0_r   <= (rs > hi);
      dpos0_r    <= (d >= 0);
      ad0_r      <= (d < 0) ? 17'(-d) : 17'(d);
      es0_r      <= erf_scale_r;
      w_r[0]     <= in_prior_weight;
      last_r[0]  <= in_last_item;
    end
  end

  // Stage 1: x = |d| * scale, form divider operands
  logic [32:0] x1_r;
  logic        hard1_r, in_hard1_r, below1_r, above1_r, dpos1_r;
  always_ff @(posedge clk) begin
    logic [48:0] den;
    if (adv) begin
      den = 49'(a0_r) + 49'(bg0_r);
      den_r[1]  <= den;
      rem_r[1]  <= 49'(a0_r);
      zd_r[1]   <= (den == 49'd0);
      x1_r      <= 33'(ad0_r) * 33'(es0_r);
      hard1_r   <= hard0_r;
      in_hard1_r<= in_hard0_r;
      below1_r  <= below0_r;
      above1_r  <= above0_r;
      dpos1_r   <= dpos0_r;
      w_r[1]    <= w_r[0];
      last_r[1] <= last_r[0];
    end
  end

  // Stage 2: table lookup of neighbours
  localparam int PW = 33 + DEPTH_LOG2;
  logic [TW-1:0] elo2_r, ehi2_r;
  logic [19:0]   fr2_r;
  logic          sat2_r, hard2_r, in_hard2_r, below2_r, above2_r, dpos2_r;
  always_ff @(posedge clk) begin
    logic [PW+1:0] pos;
    logic [PW+1:0] idx;
    logic [IW-1:0] ix;
    if (adv) begin
      pos = (PW+2)'(x1_r) * (PW+2)'(ERF_TABLE_DEPTH);
      pos = pos >> 2;
      idx = pos >> 20;
      ix  = IW'(idx);
      sat2_r <= (idx >= (PW+2)'(ERF_TABLE_DEPTH));
      if (idx >= (PW+2)'(ERF_TABLE_DEPTH)) begin
        elo2_r <= ONE;
        ehi2_r <= ONE;
      end else begin
        elo2_r <= ERF_TAB[ix];
        ehi2_r <= ERF_TAB[ix + IW'(1)];
      end
      fr2_r      <= pos[19:0];
      hard2_r    <= hard1_r;
      in_hard2_r <= in_hard1_r;
      below2_r   <= below1_r;
      above2_r   <= above1_r;
      dpos2_r    <= dpos1_r;
    end
  end

  // Stage 3: interpolate and resolve theta
  always_ff @(posedge clk) begin
    logic [TW+19:0] ip;
    logic [TW-1:0] ev;
    if (adv) begin
      ip = (TW+20)'(ehi2_r - elo2_r) * (TW+20)'(fr2_r);
      ev = sat2_r ? ONE : TW'(elo2_r + TW'(ip >> 20));
      if (hard2_r)       th_r[3] <= in_hard2_r ? ONE : '0;
      else if (below2_r) th_r[3] <= ONE;
      else if (above2_r) th_r[3] <= '0;
      else if (dpos2_r)  th_r[3] <= TW'((ONE + ev) >> 1);
      else               th_r[3] <= TW'((ONE - ev) >> 1);
    end
  end

  // Divider stages: one quotient bit each, first stage gives the integer bit
  for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_div
    logic [FRAC_BITS:0] q_in;
    logic [49:0]        rr;
    logic               take;
    if (s == 1) begin : g_int
      assign q_in = '0;
      assign rr   = {1'b0, rem_r[s]};
    end else begin : g_frac
      assign q_in = q_r[s];
      assign rr   = {rem_r[s], 1'b0};
    end
    assign take = (rr >= 50'(den_r[s]));
    always_ff @(posedge clk) begin
      if (adv) begin
        q_r[s+1]  <= {q_in[FRAC_BITS-1:0], take};
        zd_r[s+1] <= zd_r[s];
      end
    end
    // Pass the remainder on to the next quotient bit
    if (s < DIV_STAGES) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[s+1] <= take ? 49'(rr - 50'(den_r[s])) : 49'(rr);
          den_r[s+1] <= den_r[s];
        end
      end
    end
  end

  // Carry weight, last flag and theta alongside the divider
  for (genvar s = 2; s < NST; s++) begin : g_carry
    always_ff @(posedge clk) begin
      if (adv) last_r[s] <= last_r[s-1];
    end
  end
  for (genvar s = 2; s <= SP + 1; s++) begin : g_w
    always_ff @(posedge clk) begin
      if (adv) w_r[s] <= w_r[s-1];
    end
  end
  for (genvar s = 4; s < NST; s++) begin : g_th
    always_ff @(posedge clk) begin
      if (adv) th_r[s] <= th_r[s-1];
    end
  end

  // Stage SP+1: take p; SP+2: p*w; SP+3: *theta; SP+4: saturate and hold
  logic [TW-1:0] p_r [SP:SP+3];
  logic [TW+15:0] pw_r;
  logic [2*TW+15:0] wt_r;
  logic [TW-1:0] wfin_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      p_r[SP]   <= zd_r[SP] ? '0 : TW'(q_r[SP]);
      p_r[SP+1] <= p_r[SP];
      p_r[SP+2] <= p_r[SP+1];
      p_r[SP+3] <= p_r[SP+2];
      pw_r      <= ((TW+16)'(p_r[SP]) * (TW+16)'(w_r[SP+1])) >> 15;
      wt_r      <= ((2*TW+16)'(pw_r) * (2*TW+16)'(th_r[SP+2])) >> FRAC_BITS;
      wfin_r    <= (wt_r > (2*TW+16)'(ONE)) ? ONE : TW'(wt_r);
    end
  end

  assign out_valid           = vld_r[NST-1];
  assign out_membership_prob = 16'(p_r[SP+3]);
  assign out_radial_factor   = 16'(th_r[NST-1]);
  assign out_member_weight   = 16'(wfin_r);
  assign out_last_out        = last_r[NST-1];

  // A stalled result must hold until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_member_weight))
    else $error("result changed while stalled");
  // Theta never exceeds one
  a_th: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_radial_factor <= 16'(ONE))
    else $error("theta above one");
  // Weight never exceeds one
  a_wt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_member_weight <= 16'(ONE))
    else $error("weight above one");
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking bench for the membership probability weight block.
// Depends on mpw_pkg and membership_probability_weight.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import mpw_pkg::*;

  localparam int DEPTH = 256;
  localparam int FB = 15;
  localparam longint unsigned ONE = 64'd1 << FB;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [31:0] ucount;
    logic [31:0] bg;
    logic [15:0] rad;
    logic [15:0] w;
    logic        last;
  } galaxy_t;

  typedef struct packed {
    logic [15:0] p;
    logic [15:0] theta;
    logic [15:0] wt;
    logic        last;
  } member_t;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready;
  logic [31:0] in_model_density = 0, in_background_density = 0;
  logic [15:0] in_radius = 0, in_prior_weight = 0;
  logic in_last_item = 0;
  logic out_valid, out_ready = 0;
  logic [15:0] out_membership_prob, out_radial_factor, out_member_weight;
  logic out_last_out;
  logic cfg_we = 0;
  logic [1:0] cfg_index = 0;
  logic [31:0] cfg_wdata = 0;

  membership_probability_weight dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Shadow registers and erf table
  longint unsigned lam, rcut, rsig, escale;
  longint unsigned erf_lut [DEPTH+1];
  member_t pending [$];
  int errors = 0, mismatches = 0, received = 0, cycles = 0;
  bit hold_off = 0;
  bit drain_done = 0;

  function automatic longint unsigned div_frac(longint unsigned num, longint unsigned den);
    longint unsigned q, r;
    q = 0; r = num;
    if (r >= den) begin q = 1; r -= den; end
    for (int i = 0; i < FB; i++) begin
      q <<= 1; r <<= 1;
      if (r >= den) begin r -= den; q |= 1; end
    end
    return q;
  endfunction

  task automatic build_erf();
    longint unsigned u, t, e, q, q2, g, r, s, gn;
    u = (64'd1 << 32) / (DEPTH * DEPTH);
    t = 64'd1 << 28; e = t; s = 0;
    for (int k = 1; k <= 8; k++) begin
      t = ((t * u) >> 28) / k;
      if (k & 1) e -= t; else e += t;
    end
    q = e; q2 = (q * q) >> 28; g = 64'd1 << 28; r = q;
    erf_lut[0] = 0;
    for (int k = 0; k < DEPTH; k++) begin
      gn = (g * r) >> 28;
      s += g + gn;
      erf_lut[k+1] = s;
      g = gn;
      r = (r * q2) >> 28;
    end
    for (int k = 0; k <= DEPTH; k++) erf_lut[k] = div_frac(erf_lut[k], s);
  endtask

  function automatic member_t weigh_galaxy(galaxy_t gx);
    longint unsigned a, den, p, theta, wt, ad, pos, idx, fr, ev;
    longint lo, hi, rs, d;
    member_t m;
    a = (lam * gx.ucount) >> 16;
    den = a + gx.bg;
    p = (den == 0) ? 0 : div_frac(a, den);
    if (rsig == 0) begin
      theta = (gx.rad < rcut) ? ONE : 0;
    end else begin
      lo = longint'(rcut) - 5 * longint'(rsig);
      hi = longint'(rcut) + 5 * longint'(rsig);
      rs = longint'(gx.rad);
      if (rs < lo) theta = ONE;
      else if (rs > hi) theta = 0;
      else begin
        d = longint'(rcut) - rs;
        ad = (d < 0) ? -d : d;
        pos = ((ad * escale) * DEPTH) >> 2;
        idx = pos >> 20;
        fr = pos & ((64'd1 << 20) - 1);
        if (idx >= DEPTH) ev = ONE;
        else ev = erf_lut[idx] + (((erf_lut[idx+1] - erf_lut[idx]) * fr) >> 20);
        theta = (d >= 0) ? ((ONE + ev) >> 1) : ((ONE - ev) >> 1);
      end
    end
    wt = (((p * gx.w) >> 15) * theta) >> FB;
    if (wt > ONE) wt = ONE;
    m.p = p[15:0]; m.theta = theta[15:0]; m.wt = wt[15:0]; m.last = gx.last;
    return m;
  endfunction

  // Write one register, then leave the port quiet before returning
  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_LAMBDA_NORM: lam = val;
      CFG_CUT_RADIUS:  rcut = val[15:0];
      CFG_SOFT_WIDTH:  rsig = val[15:0];
      CFG_ERF_SCALE:   escale = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one item; expectation pushed on acceptance
  task automatic send_galaxy(galaxy_t gx, bit typed, member_t fixed);
    in_valid <= 1;
    {in_model_density, in_background_density, in_radius, in_prior_weight, in_last_item} <= gx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending.push_back(typed ? fixed : weigh_galaxy(gx));
  endtask

  task automatic idle_in();
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic galaxy_t rand_galaxy();
    galaxy_t gx;
    int sel;
    sel = $urandom_range(0, 9);
    gx.ucount = (sel == 0) ? 0 : (sel == 1) ? 32'hFFFFFFFF : $urandom();
    if (sel > 5) gx.ucount = $urandom_range(0, 32'h3FFFF);
    sel = $urandom_range(0, 9);
    gx.bg = (sel == 0) ? 0 : (sel == 1) ? 32'hFFFFFFFF : $urandom();
    if (sel > 5) gx.bg = $urandom_range(0, 32'h3FFFF);
    sel = $urandom_range(0, 3);
    if (sel == 0) gx.rad = 16'($urandom());
    else gx.rad = 16'(rcut + $urandom_range(0, 12 * rsig + 64) - 6 * rsig - 32);
    gx.w = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                         : 16'($urandom_range(0, 32768));
    gx.last = 1'($urandom());
    return gx;
  endfunction

  // Directed table: typed expectations only for obvious rows
  typedef struct {
    galaxy_t gx;
    bit      typed;
    member_t exp_m;
  } vec_t;
  vec_t dir_tab [$];

  task automatic add_row(galaxy_t gx, bit typed, member_t m);
    vec_t v;
    v.gx = gx; v.typed = typed; v.exp_m = m;
    dir_tab.push_back(v);
  endtask

  // Receiver: stall pattern plus a long hold-off
  initial begin
    int pat;
    pat = 0;
    while (1) begin
      @(posedge clk);
      pat++;
      if (hold_off) out_ready <= 0;
      else if (pat % 200 < 60) out_ready <= 1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Check results
  always @(posedge clk) begin
    member_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_membership_prob, out_radial_factor, out_member_weight, out_last_out};
      if (pending.size() == 0) begin
        errors++;
        $display("unexpected result %h", got);
      end else begin
        want = pending.pop_front();
        received++;
        if (got !== want) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp p=%h th=%h w=%h l=%b got p=%h th=%h w=%h l=%b",
                     want.p, want.theta, want.wt, want.last,
                     got.p, got.theta, got.wt, got.last);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    member_t m;
    int burst;
    lam = 65536; rcut = 4096; rsig = 0; escale = 0;
    build_erf();
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Reset values: hard cut at 1.0, norm 1.0
    add_row('{32'h10000, 0, 16'd0, 16'h8000, 1'b1}, 1, '{16'h8000, 16'h8000, 16'h8000, 1'b1});
    add_row('{0, 0, 16'd0, 16'h8000, 1'b0}, 1, '{16'h0, 16'h8000, 16'h0, 1'b0});
    add_row('{32'h10000, 0, 16'd4096, 16'h8000, 1'b0}, 1, '{16'h8000, 16'h0, 16'h0, 1'b0});
    add_row('{32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 1'b1}, 1,
            '{16'h4000, 16'h0, 16'h0, 1'b1});
    add_row('{0, 32'hFFFFFFFF, 16'd4095, 16'h8000, 1'b0}, 1, '{16'h0, 16'h8000, 16'h0, 1'b0});
    add_row('{32'h10000, 32'h10000, 16'd0, 16'h8000, 1'b0}, 0, m);
    add_row('{32'hFFFFFFFF, 0, 16'd0, 16'hFFFF, 1'b1}, 0, m);
    add_row('{32'h12345, 32'h6789A, 16'd100, 16'h4000, 1'b0}, 0, m);
    foreach (dir_tab[i]) send_galaxy(dir_tab[i].gx, dir_tab[i].typed, dir_tab[i].exp_m);
    idle_in();
    drain();

    // Soft cut rows at extremes, checked by the predictor
    write_reg(CFG_LAMBDA_NORM, 32'hFFFFFFFF);
    write_reg(CFG_CUT_RADIUS, 16'h2000);
    write_reg(CFG_SOFT_WIDTH, 16'h0100);
    write_reg(CFG_ERF_SCALE, 16'h0B50);
    send_galaxy('{32'h1, 32'h1, 16'h2000, 16'h8000, 1'b0}, 0, m);
    send_galaxy('{32'h1, 32'h0, 16'h1B00, 16'h8000, 1'b0}, 0, m);
    send_galaxy('{32'h1, 32'h0, 16'h2500, 16'h8000, 1'b0}, 0, m);
    send_galaxy('{32'h1, 32'h0, 16'h2501, 16'h8000, 1'b0}, 0, m);
    send_galaxy('{32'h1, 32'h0, 16'h1AFF, 16'hFFFF, 1'b1}, 0, m);
    send_galaxy('{32'h1, 32'h0, 16'h2080, 16'h8000, 1'b0}, 0, m);
    send_galaxy('{32'h1, 32'h0, 16'h0, 16'h0, 1'b0}, 0, m);
    idle_in();
    drain();
    write_reg(CFG_ERF_SCALE, 16'h0);
    write_reg(CFG_SOFT_WIDTH, 16'hFFFF);
    write_reg(CFG_CUT_RADIUS, 16'hFFFF);
    send_galaxy('{32'h10, 32'h10, 16'h0, 16'h8000, 1'b0}, 0, m);
    send_galaxy('{32'h10, 32'h10, 16'hFFFF, 16'h8000, 1'b1}, 0, m);
    idle_in();
    drain();

    // Random phases across several settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_LAMBDA_NORM, 32'h0); write_reg(CFG_SOFT_WIDTH, 0);
                 write_reg(CFG_CUT_RADIUS, 0); end
        1: begin write_reg(CFG_LAMBDA_NORM, 32'h10000); write_reg(CFG_CUT_RADIUS, 16'h1000); end
        2: begin write_reg(CFG_LAMBDA_NORM, $urandom()); write_reg(CFG_SOFT_WIDTH, 16'h0080);
                 write_reg(CFG_ERF_SCALE, 16'h1000); end
        3: begin write_reg(CFG_CUT_RADIUS, 16'($urandom())); write_reg(CFG_SOFT_WIDTH, 16'h0040);
                 write_reg(CFG_ERF_SCALE, 16'hFFFF); end
        4: begin write_reg(CFG_LAMBDA_NORM, $urandom_range(1, 32'h40000));
                 write_reg(CFG_SOFT_WIDTH, 16'h0400); write_reg(CFG_ERF_SCALE, 16'h02D4); end
        5: begin write_reg(CFG_SOFT_WIDTH, 16'($urandom_range(1, 4096)));
                 write_reg(CFG_ERF_SCALE, 16'($urandom())); end
        default: ;
      endcase
      // Long receiver hold-off while sender keeps offering
      if (ph == 2) begin
        fork
          begin hold_off = 1; repeat (150) @(posedge clk); hold_off = 0; end
        join_none
      end
      for (int n = 0; n < 89; ) begin
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst && n < 89; b++) begin
          send_galaxy(rand_galaxy(), 0, m);
          n++;
        end
        repeat ($urandom_range(0, 5)) idle_in();
      end
      idle_in();
      drain();
    end

    $display("Covered hard and soft cuts, empty denominators and saturation over %0d results.",
             received);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
sv/mpw_pkg.sv
sv/membership_probability_weight.sv
sim/testbench.sv
